[rtl/count_smaller_after_self_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for count_smaller_after_self_unit
// Clocked checks on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef COUNT_SMALLER_AFTER_SELF_UNIT_ASSERT_SVH
`define COUNT_SMALLER_AFTER_SELF_UNIT_ASSERT_SVH

// Property must hold at every edge outside reset
`define CSAS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define CSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/csas_pkg.sv]
// ----------------------------------------------------------------------------
// csas_pkg
// Shared types and constants of the count-smaller-after-self unit.
// ----------------------------------------------------------------------------
package csas_pkg;

    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 4;
    localparam int POS_W            = 4;
    localparam int MAX_ELEMENTS_DEF = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [POS_W-1:0]   POS_LAST  = {POS_W{1'b1}};

    // Input word
    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      set_end;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] smaller_after;
        logic               dropped_flag;
        logic               final_result;
    } out_word_t;

    // Contents of one cell
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } cell_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic ingest;   // a new value is taken in this cycle
        logic shift;    // chain moves one place toward cell 0
        logic clear;    // set is done, empty every cell
    } cell_ctrl_t;

endpackage

[rtl/csas_cell.sv]
// ----------------------------------------------------------------------------
// csas_cell
// One compare-and-count cell: holds a value and how many later values were
// strictly smaller. Loads when it is the first empty cell, shifts toward
// cell 0 while the set is read out.
// ----------------------------------------------------------------------------
module csas_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  csas_pkg::cell_ctrl_t                ctrl,
    input  logic signed [csas_pkg::VALUE_W-1:0] in_value,
    input  logic                                left_valid,
    input  csas_pkg::cell_t                     right_cell,
    output csas_pkg::cell_t                     cell_out
);

    logic                                valid_reg;
    logic signed [csas_pkg::VALUE_W-1:0] value_reg;
    logic [csas_pkg::COUNT_W-1:0]        count_reg;

    logic is_greater;

    // Stored value strictly above the newcomer
    assign is_greater = value_reg > in_value;

    // Occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= right_cell.valid;
        end else if (ctrl.ingest && !valid_reg && left_valid) begin
            valid_reg <= 1'b1;
        end
    end

    // Value and running count
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            value_reg <= right_cell.value;
            count_reg <= right_cell.count;
        end else if (ctrl.ingest) begin
            if (valid_reg) begin
                if (is_greater && count_reg != csas_pkg::COUNT_MAX) begin
                    count_reg <= count_reg + 1'b1;
                end
            end else if (left_valid) begin
                value_reg <= in_value;
                count_reg <= '0;
            end
        end
    end

    assign cell_out = '{valid: valid_reg, value: value_reg, count: count_reg};

endmodule

[rtl/count_smaller_after_self_unit.sv]
// ----------------------------------------------------------------------------
// count_smaller_after_self_unit
// For each value of a set, counts the later values that are strictly smaller.
// ----------------------------------------------------------------------------
// Values enter one word per cycle into a row of MAX_ELEMENTS cells; every
// occupied cell compares itself with the newcomer in the same cycle and the
// first empty cell stores it. Once the word flagged set_end is taken, the
// input is held off and results leave from cell 0 one per cycle (while m_ready
// is high) as the row shifts toward it, in arrival order: min(n, MAX_ELEMENTS,
// 16) results for a set of n values, after which the row is empty and the next
// set may start. Values arriving to a full row are dropped and reported through
// dropped_flag on every result of that set. Counts saturate at 15.
// ----------------------------------------------------------------------------
module count_smaller_after_self_unit #(
    parameter int MAX_ELEMENTS = csas_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csas_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output csas_pkg::out_word_t m_data
);

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    state_t                     state_reg;
    logic                       overflow_reg;
    logic [csas_pkg::POS_W-1:0] pos_reg;

    csas_pkg::cell_t      cells [MAX_ELEMENTS+1];
    logic [MAX_ELEMENTS-1:0] vld;
    csas_pkg::cell_ctrl_t ctrl;

    logic in_fire;
    logic out_fire;
    logic row_full;
    logic last_out;

    // Handshakes
    assign s_ready  = (state_reg == ST_COLLECT);
    assign m_valid  = (state_reg == ST_DRAIN);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign row_full = vld[MAX_ELEMENTS-1];

    // Last result: next cell empty or result limit reached
    assign last_out = !cells[1].valid || (pos_reg == csas_pkg::POS_LAST);

    // Cell control
    assign ctrl.ingest = in_fire && !row_full;
    assign ctrl.shift  = out_fire;
    assign ctrl.clear  = out_fire && last_out;

    // Row of cells; the slot past the end is always empty
    assign cells[MAX_ELEMENTS] = '0;

    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        logic left_v;
        if (i == 0) begin : g_first
            assign left_v = 1'b1;
        end else begin : g_rest
            assign left_v = cells[i-1].valid;
        end

        csas_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .in_value   (s_data.sample_value),
            .left_valid (left_v),
            .right_cell (cells[i+1]),
            .cell_out   (cells[i])
        );

        assign vld[i] = cells[i].valid;
    end

    // Sequencer: collect until the end word, then drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            overflow_reg <= 1'b0;
            pos_reg      <= '0;
        end else begin
            case (state_reg)
                ST_COLLECT: begin
                    if (in_fire) begin
                        if (row_full) begin
                            overflow_reg <= 1'b1;
                        end
                        if (s_data.set_end) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    pos_reg <= '0;
                end
                ST_DRAIN: begin
                    if (out_fire) begin
                        pos_reg <= pos_reg + 1'b1;
                        if (last_out) begin
                            state_reg    <= ST_COLLECT;
                            overflow_reg <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    // Result word from the head cell
    assign m_data = '{
        position:      pos_reg,
        smaller_after: cells[0].count,
        dropped_flag:  overflow_reg,
        final_result:  last_out
    };

    `include "count_smaller_after_self_unit_assert.svh"

    `CSAS_ASSERT_ALWAYS(a_drain_head_valid, !m_valid || cells[0].valid, "drain from empty cell")
    `CSAS_ASSERT_ALWAYS(a_one_side_open, !(s_ready && m_valid), "input open during drain")
    `CSAS_ASSERT_ALWAYS(a_row_packed, (vld & (vld + MAX_ELEMENTS'(1))) == '0, "gap in cell row")
    `CSAS_ASSERT_NEXT(a_clear_after_final, ctrl.clear, s_ready && vld == '0, "row kept after set")

endmodule
